// ===== sv/itoda_pkg.sv =====
// Shared constants and types for the grouped decimal text formatter.
// Used by itoda_dabble, itoda_emit and int_to_decimal_ascii_grouped_core.
`timescale 1ns / 1ps

package itoda_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
  localparam int DIGITS     = (VALUE_BITS - 1) * 30103 / 100000 + 1;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int IDX_W      = $clog2(DIGITS);
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // finished conversion handed from the converter to the emitter
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } bcd_word_t;

endpackage

// ===== sv/itoda_dabble.sv =====
// Bit-serial double-dabble converter: signed binary in, sign and BCD digits out.
// Depends on itoda_pkg.
`timescale 1ns / 1ps

module itoda_dabble
  import itoda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bcd_word_t             out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [BCD_W-1:0]      bcd_q;
  logic                  neg_q;
  logic [BCD_W-1:0]      bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_DONE);
  assign out_word_o.neg = neg_q;
  assign out_word_o.bcd = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SHIFT;
            cnt_q   <= '0;
          end
        end
        ST_SHIFT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath: magnitude shifts out MSB first into the BCD register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      neg_q <= in_value_i[VALUE_BITS-1];
      mag_q <= in_value_i[VALUE_BITS-1] ? (~in_value_i + 1'b1) : in_value_i;
      bcd_q <= '0;
    end else if (state_q == ST_SHIFT) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== sv/itoda_emit.sv =====
// Character emitter: walks the BCD digits MSD first, drops leading zeros,
// inserts sign and group commas, and holds each character in an output register.
// Depends on itoda_pkg.
`timescale 1ns / 1ps

module itoda_emit
  import itoda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcd_word_t         in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_COMMA
  } state_e;

  localparam logic [1:0] GRP_START = 2'((DIGITS - 1) % 3);

  state_e            state_q;
  logic [BCD_W-1:0]  dig_q;
  logic [IDX_W-1:0]  idx_q;
  logic [1:0]        grp_q;
  logic              neg_q;
  logic              vld_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              slot_free;
  logic              emit_fire;
  logic [3:0]        top_digit;
  logic [1:0]        grp_next;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign slot_free   = !vld_q || out_ready_i;
  assign emit_fire   = slot_free &&
                       (state_q == ST_SIGN || state_q == ST_DIGIT || state_q == ST_COMMA);
  assign top_digit   = dig_q[BCD_W-1 -: 4];
  assign grp_next    = (grp_q == 2'd0) ? 2'd2 : grp_q - 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      if (emit_fire) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_digit != 4'd0 || idx_q == '0) begin
            state_q <= neg_q ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (slot_free) begin
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else if (grp_q == 2'd0) begin
              state_q <= ST_COMMA;
            end
          end
        end
        ST_COMMA: begin
          if (slot_free) begin
            state_q <= ST_DIGIT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload: digit shift register, position counters and the output character
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dig_q <= in_word_i.bcd;
          neg_q <= in_word_i.neg;
          idx_q <= IDX_W'(DIGITS - 1);
          grp_q <= GRP_START;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && idx_q != '0) begin
          dig_q <= {dig_q[BCD_W-5:0], 4'd0};
          idx_q <= idx_q - 1'b1;
          grp_q <= grp_next;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          char_q <= CHAR_MINUS;
          last_q <= 1'b0;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          char_q <= CHAR_ZERO + {3'b000, top_digit};
          last_q <= (idx_q == '0);
          // advance now unless a comma follows this digit
          if (idx_q != '0 && grp_q != 2'd0) begin
            dig_q <= {dig_q[BCD_W-5:0], 4'd0};
            idx_q <= idx_q - 1'b1;
            grp_q <= grp_next;
          end
        end
      end
      ST_COMMA: begin
        if (slot_free) begin
          char_q <= CHAR_COMMA;
          last_q <= 1'b0;
          dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
          idx_q  <= idx_q - 1'b1;
          grp_q  <= grp_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/int_to_decimal_ascii_grouped_core.sv =====
// Signed integer to grouped decimal ASCII text, one character per output request.
// Usage:
//   s_axis carries one signed VALUE_BITS-bit integer per request in tdata.
//   m_axis returns its text most significant character first: a leading '-'
//   for negatives, commas between groups of three digits, '0' for zero.
//   tdata[6:0] is the ASCII character, tlast marks the final character.
// Timing:
//   A converter shifts the magnitude through a BCD register one bit per cycle;
//   the emitter then drops up to DIGITS-1 leading zeros and sends one character
//   per cycle while the receiver accepts. The converter takes a new value while
//   the emitter still sends the previous text.
// Reset clears both controllers; no text is pending afterwards.
// A stalled receiver holds the current character in the output register and
// backs pressure up through the emitter to the converter and s_axis_tready_o.
// Depends on itoda_pkg, itoda_dabble and itoda_emit.
`timescale 1ns / 1ps

module int_to_decimal_ascii_grouped_core
  import itoda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [VALUE_BITS-1:0] s_axis_tdata_i,   // [VALUE_BITS-1:0] value
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // [6:0] character, [7] zero pad
  output logic                  m_axis_tlast_o    // last
);

  bcd_word_t         word;
  logic              word_valid;
  logic              word_ready;
  logic [CHAR_W-1:0] char_out;

  itoda_dabble u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_value_i (s_axis_tdata_i),
    .out_valid_o(word_valid),
    .out_ready_i(word_ready),
    .out_word_o (word)
  );

  itoda_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (word_valid),
    .in_ready_o (word_ready),
    .in_word_i  (word),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_char_o (char_out),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, char_out};

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for int_to_decimal_ascii_grouped_core: random and edge values in,
// grouped decimal text out, each character checked against a local formatter.
// Depends on itoda_pkg and int_to_decimal_ascii_grouped_core.
`timescale 1ns / 1ps

module tb;
  import itoda_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    int                    gap;
    bit                    drain;
  } value_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_BITS-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tlast;

  text_char_t  text_q[$];
  value_req_t  pending_q[$];
  value_req_t  cur_req;
  bit          have_req = 1'b0;
  int          gap_left = 0;
  bit          s_taken = 1'b0;
  bit          m_taken = 1'b0;
  int          rx_wait = 0;
  bit          rx_burst = 1'b0;
  int          hold_start = 0;
  int          hold_left = 0;
  bit          rx_hold = 1'b0;
  int          sent_cnt = 0;
  int          accepted_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  int_to_decimal_ascii_grouped_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("int_to_decimal_ascii_grouped_core test failed");
      $finish;
    end
  end

  // Expected text of one value: sign, digits with commas every three from the right.
  function automatic void push_text(logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            dig[$];
    text_char_t            txt[$];
    text_char_t            c;
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      dig.push_back(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    c.last = 1'b0;
    if (v[VALUE_BITS-1]) begin
      c.ch = CHAR_MINUS;
      txt.push_back(c);
    end
    for (int i = dig.size() - 1; i >= 0; i--) begin
      c.ch = CHAR_ZERO + CHAR_W'(dig[i]);
      txt.push_back(c);
      if (i != 0 && i % 3 == 0) begin
        c.ch = CHAR_COMMA;
        txt.push_back(c);
      end
    end
    txt[txt.size() - 1].last = 1'b1;
    foreach (txt[i]) text_q.push_back(txt[i]);
  endfunction

  task automatic report_bad(string msg);
    if (err_cnt < 10) $display("%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Sample both handshakes at the rising edge; predict on input, check on output.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      s_taken <= s_tvalid && s_tready;
      m_taken <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        push_text(s_tdata);
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          report_bad($sformatf("unexpected char data=%h last=%b", m_tdata, m_tlast));
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last)
            report_bad($sformatf("char mismatch: expected data=%h last=%b, got data=%h last=%b",
                                 {1'b0, want.ch}, want.last, m_tdata, m_tlast));
        end
      end
    end
  end

  // Value driver: wait out each request's gap and drain flag, then hold it until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!(s_tvalid && !s_taken)) begin
      if (!have_req && pending_q.size() > 0) begin
        cur_req  = pending_q.pop_front();
        have_req = 1'b1;
        gap_left = cur_req.gap;
      end
      if (have_req && gap_left == 0 && !(cur_req.drain && text_q.size() != 0)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= cur_req.value;
        have_req = 1'b0;
      end else begin
        s_tvalid <= 1'b0;
        if (have_req && gap_left > 0) gap_left--;
      end
    end
  end

  // Long receiver hold-off, counted here and passed to the receiver through the rx_hold register.
  always @(negedge clk_i) begin
    if (hold_start > 0) begin
      hold_left  = hold_start;
      hold_start = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    rx_hold <= (hold_left > 0);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_taken) rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] p;
    p = 1;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 9999);
      2: v = '0 - VALUE_BITS'($urandom_range(0, 9999));
      3: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + VALUE_BITS'($urandom_range(0, 2)) - 1'b1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 3) == 0) v = '0 - v;
    return v;
  endfunction

  task automatic queue_value(logic [VALUE_BITS-1:0] v, int gap, bit drain);
    value_req_t r;
    r.value = v;
    r.gap   = gap;
    r.drain = drain;
    pending_q.push_back(r);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    while (accepted_cnt != sent_cnt || text_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [VALUE_BITS-1:0] edge_vals[$];
    int mode;
    edge_vals = '{0, 1, -1, 9, 10, -10, 99, 100, 999, -999, 1000, -1000, 999999,
                  1000000, 999999999, 1000000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000001, 1234567890, -1234567890, 32'h55555555, 32'hAAAAAAAA};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_vals[i]) queue_value(edge_vals[i], $urandom_range(0, 15), 1'b0);
    wait_idle();

    // Stall the receiver while values keep coming back to back.
    @(posedge clk_i);
    hold_start = 400;
    repeat (16) queue_value(pick_value(), 0, 1'b0);
    wait_idle();

    for (int s = 0; s < 6; s++) begin
      while (pending_q.size() != 0) @(posedge clk_i);
      mode = $urandom_range(0, 2);
      rx_burst = (mode == 1);
      for (int k = 0; k < 20; k++)
        queue_value(pick_value(), (mode == 1) ? 0 : $urandom_range(0, 15), k == 10);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0 && text_q.size() == 0) begin
      $display("int_to_decimal_ascii_grouped_core test passed");
    end else begin
      $display("int_to_decimal_ascii_grouped_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/itoda_pkg.sv
sv/itoda_dabble.sv
sv/itoda_emit.sv
sv/int_to_decimal_ascii_grouped_core.sv
tb/tb.sv
